// ===== sv/assert_macros.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CSC_ASSERT_IMPLY(name, ck, rs_n, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!(rs_n)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define CSC_ASSERT_NEXT(name, ck, rs_n, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!(rs_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== sv/csc_pkg.sv =====
package csc_pkg;

  localparam int TIME_WIDTH     = 32;
  localparam int NOW_WIDTH      = 32;
  localparam int MV_WIDTH       = 16;
  localparam int CFG_WIDTH      = 16;
  localparam int CFG_ADDR_WIDTH = 3;
  localparam int IN_DATA_WIDTH  = 56;
  localparam int OUT_DATA_WIDTH = 16;
  localparam int SNAP_WIDTH     = 11;

  typedef logic [TIME_WIDTH-1:0] tstamp_t;

  typedef struct packed {
    logic    valid;
    tstamp_t t;
  } stamp_t;

  typedef enum logic [2:0] {
    ST_NOPOWER = 3'd0,
    ST_PRE     = 3'd1,
    ST_CC      = 3'd2,
    ST_CV      = 3'd3,
    ST_FULL    = 3'd4,
    ST_NOBAT   = 3'd5,
    ST_FAULT   = 3'd6
  } charge_state_t;

  typedef enum logic [CFG_ADDR_WIDTH-1:0] {
    CFG_POWER_HOLD   = 3'd0,
    CFG_STABLE_HIGH  = 3'd1,
    CFG_ALT_WINDOW   = 3'd2,
    CFG_FAULT_HOLD   = 3'd3,
    CFG_PRECHARGE_MV = 3'd4,
    CFG_CV_ENTER_MV  = 3'd5,
    CFG_CV_CONFIRM   = 3'd6,
    CFG_DETECT_LEVEL = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] power_hold_ms;
    logic [CFG_WIDTH-1:0] stable_high_ms;
    logic [CFG_WIDTH-1:0] alternate_window_ms;
    logic [CFG_WIDTH-1:0] fault_hold_ms;
    logic [CFG_WIDTH-1:0] precharge_below_mv;
    logic [CFG_WIDTH-1:0] cv_enter_mv;
    logic [CFG_WIDTH-1:0] cv_confirm_ms;
    logic                 detect_active_level;
  } cfg_t;

  typedef struct packed {
    logic [NOW_WIDTH-1:0] now_ms;
    logic                 detect_level;
    logic                 full_level;
    logic [MV_WIDTH-1:0]  battery_millivolts;
    logic                 battery_sample_valid;
  } sample_t;

  typedef struct packed {
    charge_state_t charge_state;
    logic          ext_power;
    logic          charging;
    logic          is_full;
    logic          is_no_battery;
    logic          is_precharge;
    logic          is_constant_current;
    logic          is_constant_voltage;
    logic          is_fault;
    logic          changed;
  } result_t;

endpackage

// ===== sv/csc_cfg.sv =====
module csc_cfg
  import csc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
  input  logic [CFG_WIDTH-1:0]      cfg_wdata,
  output cfg_t                      cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.power_hold_ms       <= CFG_WIDTH'(3000);
      cfg_r.stable_high_ms      <= CFG_WIDTH'(2000);
      cfg_r.alternate_window_ms <= CFG_WIDTH'(3000);
      cfg_r.fault_hold_ms       <= CFG_WIDTH'(5000);
      cfg_r.precharge_below_mv  <= CFG_WIDTH'(3000);
      cfg_r.cv_enter_mv         <= CFG_WIDTH'(4150);
      cfg_r.cv_confirm_ms       <= CFG_WIDTH'(5000);
      cfg_r.detect_active_level <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_POWER_HOLD:   cfg_r.power_hold_ms       <= cfg_wdata;
        CFG_STABLE_HIGH:  cfg_r.stable_high_ms      <= cfg_wdata;
        CFG_ALT_WINDOW:   cfg_r.alternate_window_ms <= cfg_wdata;
        CFG_FAULT_HOLD:   cfg_r.fault_hold_ms       <= cfg_wdata;
        CFG_PRECHARGE_MV: cfg_r.precharge_below_mv  <= cfg_wdata;
        CFG_CV_ENTER_MV:  cfg_r.cv_enter_mv         <= cfg_wdata;
        CFG_CV_CONFIRM:   cfg_r.cv_confirm_ms       <= cfg_wdata;
        CFG_DETECT_LEVEL: cfg_r.detect_active_level <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/csc_core.sv =====
module csc_core
  import csc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  sample_t smp,
  input  cfg_t    cfg,
  output result_t res
);

  logic [MV_WIDTH-1:0]   mv_held_r, mv_held_nxt;
  logic                  mv_valid_r, mv_valid_nxt;
  stamp_t                power_seen_r, power_seen_nxt;
  stamp_t                det_seen_r, det_seen_nxt;
  stamp_t                full_seen_r, full_seen_nxt;
  stamp_t                det_since_r, det_since_nxt;
  stamp_t                full_since_r, full_since_nxt;
  stamp_t                both_since_r, both_since_nxt;
  stamp_t                fault_seen_r, fault_seen_nxt;
  stamp_t                cv_since_r, cv_since_nxt;
  logic                  cv_locked_r, cv_locked_nxt;
  logic [SNAP_WIDTH-1:0] snap_r, snap_nxt;

  tstamp_t       now;
  stamp_t        now_stamp;
  logic          det, full, both;
  logic          mv_valid_pre;
  logic          pwr, det_stable, full_steady, alt, nobat, fault, clear_cv;
  charge_state_t st;
  result_t       res_c;

  function automatic logic is_recent(input tstamp_t t_now, input stamp_t s,
                                     input logic [CFG_WIDTH-1:0] lim);
    tstamp_t d;
    d = t_now - s.t;
    return s.valid && (d <= TIME_WIDTH'(lim));
  endfunction

  function automatic logic held_for(input tstamp_t t_now, input stamp_t s,
                                    input logic [CFG_WIDTH-1:0] lim);
    tstamp_t d;
    d = t_now - s.t;
    return s.valid && (d >= TIME_WIDTH'(lim));
  endfunction

  always_comb begin
    now       = TIME_WIDTH'(smp.now_ms);
    now_stamp = '{valid: 1'b1, t: now};
    det       = (smp.detect_level == cfg.detect_active_level);
    full      = smp.full_level;
    both      = det && full;

    mv_held_nxt  = smp.battery_sample_valid ? smp.battery_millivolts : mv_held_r;
    mv_valid_pre = smp.battery_sample_valid || mv_valid_r;

    power_seen_nxt = (det || full) ? now_stamp : power_seen_r;
    det_seen_nxt   = det ? now_stamp : det_seen_r;
    full_seen_nxt  = full ? now_stamp : full_seen_r;
    det_since_nxt  = det ? (det_since_r.valid ? det_since_r : now_stamp) : '0;
    full_since_nxt = full ? (full_since_r.valid ? full_since_r : now_stamp) : '0;
    both_since_nxt = both ? (both_since_r.valid ? both_since_r : now_stamp) : '0;

    pwr         = is_recent(now, power_seen_nxt, cfg.power_hold_ms);
    det_stable  = held_for(now, det_since_nxt, cfg.stable_high_ms);
    full_steady = held_for(now, full_since_nxt, cfg.stable_high_ms);
    alt         = pwr && is_recent(now, det_seen_nxt, cfg.alternate_window_ms)
                      && is_recent(now, full_seen_nxt, cfg.alternate_window_ms);
    nobat       = alt && !det_stable && !full_steady;

    fault_seen_nxt = (both && held_for(now, both_since_nxt, cfg.stable_high_ms))
                   ? now_stamp : fault_seen_r;
    fault          = pwr && is_recent(now, fault_seen_nxt, cfg.fault_hold_ms);

    clear_cv      = 1'b1;
    cv_since_nxt  = cv_since_r;
    cv_locked_nxt = cv_locked_r;
    mv_valid_nxt  = mv_valid_pre;
    st            = ST_NOPOWER;

    priority if (!pwr) begin
      st           = ST_NOPOWER;
      mv_valid_nxt = 1'b0;
    end else if (fault) begin
      st = ST_FAULT;
    end else if (nobat) begin
      st = ST_NOBAT;
    end else if (full_steady) begin
      st = ST_FULL;
    end else if (mv_valid_pre && (mv_held_nxt < cfg.precharge_below_mv)) begin
      st = ST_PRE;
    end else begin
      clear_cv = 1'b0;
      if (!cv_locked_r && mv_valid_pre && (mv_held_nxt >= cfg.cv_enter_mv)) begin
        if (!cv_since_r.valid) begin
          cv_since_nxt = now_stamp;
        end else if (held_for(now, cv_since_r, cfg.cv_confirm_ms)) begin
          cv_locked_nxt = 1'b1;
        end
      end else if (!cv_locked_r) begin
        cv_since_nxt = '0;
      end
      st = cv_locked_nxt ? ST_CV : ST_CC;
    end

    if (clear_cv) begin
      cv_since_nxt  = '0;
      cv_locked_nxt = 1'b0;
    end
  end

  always_comb begin
    res_c.charge_state        = st;
    res_c.ext_power           = pwr;
    res_c.charging            = (st == ST_PRE) || (st == ST_CC) || (st == ST_CV);
    res_c.is_full             = (st == ST_FULL);
    res_c.is_no_battery       = (st == ST_NOBAT);
    res_c.is_precharge        = (st == ST_PRE);
    res_c.is_constant_current = (st == ST_CC);
    res_c.is_constant_voltage = (st == ST_CV);
    res_c.is_fault            = (st == ST_FAULT);
    snap_nxt = {res_c.is_fault, res_c.is_constant_voltage, res_c.is_constant_current,
                res_c.is_precharge, res_c.is_no_battery, res_c.is_full,
                res_c.charging, res_c.ext_power, st};
    res_c.changed             = (snap_nxt != snap_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_held_r    <= '0;
      mv_valid_r   <= 1'b0;
      power_seen_r <= '0;
      det_seen_r   <= '0;
      full_seen_r  <= '0;
      det_since_r  <= '0;
      full_since_r <= '0;
      both_since_r <= '0;
      fault_seen_r <= '0;
      cv_since_r   <= '0;
      cv_locked_r  <= 1'b0;
      snap_r       <= '0;
    end else if (step) begin
      mv_held_r    <= mv_held_nxt;
      mv_valid_r   <= mv_valid_nxt;
      power_seen_r <= power_seen_nxt;
      det_seen_r   <= det_seen_nxt;
      full_seen_r  <= full_seen_nxt;
      det_since_r  <= det_since_nxt;
      full_since_r <= full_since_nxt;
      both_since_r <= both_since_nxt;
      fault_seen_r <= fault_seen_nxt;
      cv_since_r   <= cv_since_nxt;
      cv_locked_r  <= cv_locked_nxt;
      snap_r       <= snap_nxt;
    end
  end

  assign res = res_c;

endmodule

// ===== sv/charger_status_classifier.sv =====
// Charger status classifier.
// in_* is the tick stream: one beat per sample tick with timestamp, raw pin
// levels and an optional fresh battery voltage. out_* carries one result beat
// per tick: the charge state, decoded flags and a changed bit.
// cfg_* writes the eight timing/threshold registers, one per cycle while
// cfg_we is high; write only while no tick is in flight.
// An accepted tick waits in the input register, is classified combinationally
// and is written into the result register, which drives out_*.
// Throughput is one tick per cycle while the receiver takes results, set by
// the single compare/classify stage between the input register and the result
// register; all tracked state updates in that same cycle.
// Reset (rst_n low, synchronous) empties both registers, loads the default
// register values and clears every timestamp, the CV latch and the held
// voltage; the first result after reset compares against "no power".
// When the receiver stalls, the result is held, the waiting input beat is
// held, and in_tready drops once both registers are full.
`include "assert_macros.svh"

module charger_status_classifier
  import csc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // now_ms[31:0], detect_level[32], full_level[33], battery_millivolts[49:34],
  // battery_sample_valid[50], zero pad[55:51]
  input  logic [IN_DATA_WIDTH-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // charge_state[2:0], ext_power[3], charging[4], is_full[5],
  // is_no_battery[6], is_precharge[7], is_constant_current[8],
  // is_constant_voltage[9], is_fault[10], changed[11], zero pad[15:12]
  output logic [OUT_DATA_WIDTH-1:0] out_tdata,
  input  logic                      cfg_we,
  input  logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
  input  logic [CFG_WIDTH-1:0]      cfg_wdata
);

  logic    in_valid_r, in_valid_nxt;
  sample_t in_data_r;
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;
  logic    step, in_take;
  sample_t smp_in;
  cfg_t    cfg;
  result_t res;

  assign smp_in = '{now_ms:               in_tdata[31:0],
                    detect_level:         in_tdata[32],
                    full_level:           in_tdata[33],
                    battery_millivolts:   in_tdata[49:34],
                    battery_sample_valid: in_tdata[50]};

  assign step      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;
  assign in_take   = in_tvalid && in_tready;

  assign in_valid_nxt  = in_take || (in_valid_r && !step);
  assign out_valid_nxt = step || (out_valid_r && !out_tready);

  csc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  csc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .smp   (in_data_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= smp_in;
    end
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000,
                       out_res_r.changed,
                       out_res_r.is_fault,
                       out_res_r.is_constant_voltage,
                       out_res_r.is_constant_current,
                       out_res_r.is_precharge,
                       out_res_r.is_no_battery,
                       out_res_r.is_full,
                       out_res_r.charging,
                       out_res_r.ext_power,
                       out_res_r.charge_state};

  `CSC_ASSERT_NEXT(a_step_fills_out, clk, rst_n, step, out_valid_r)
  `CSC_ASSERT_IMPLY(a_ready_when_out_empty, clk, rst_n, !out_valid_r, in_tready)
  `CSC_ASSERT_IMPLY(a_state_onehot, clk, rst_n, out_valid_r,
    $onehot({out_res_r.charge_state == ST_NOPOWER, out_res_r.is_full,
             out_res_r.is_no_battery, out_res_r.is_precharge,
             out_res_r.is_constant_current, out_res_r.is_constant_voltage,
             out_res_r.is_fault}))
  `CSC_ASSERT_IMPLY(a_nopower_flag, clk, rst_n, out_valid_r,
    out_res_r.ext_power == (out_res_r.charge_state != ST_NOPOWER))

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb
  import csc_pkg::*;
;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 600;

  typedef struct packed {
    charge_state_t state;
    logic          ext_power;
    logic          charging;
    logic          is_full;
    logic          is_no_battery;
    logic          is_precharge;
    logic          is_constant_current;
    logic          is_constant_voltage;
    logic          is_fault;
    logic          changed;
  } status_t;

  typedef struct packed {
    logic [31:0]   now;
    logic          det_raw;
    logic          full_raw;
    logic [15:0]   mv;
    logic          mv_ok;
    logic          typed;
    charge_state_t st;
    logic          pwr;
    logic          chg;
  } script_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_tvalid;
  logic                      in_tready;
  // now_ms[31:0], detect_level[32], full_level[33], battery_millivolts[49:34],
  // battery_sample_valid[50], zero pad[55:51]
  logic [IN_DATA_WIDTH-1:0]  in_tdata;
  logic                      out_tvalid;
  logic                      out_tready;
  // charge_state[2:0], ext_power[3], charging[4], is_full[5],
  // is_no_battery[6], is_precharge[7], is_constant_current[8],
  // is_constant_voltage[9], is_fault[10], changed[11], zero pad[15:12]
  logic [OUT_DATA_WIDTH-1:0] out_tdata;
  logic                      cfg_we;
  logic [CFG_ADDR_WIDTH-1:0] cfg_addr;
  logic [CFG_WIDTH-1:0]      cfg_wdata;

  charger_status_classifier u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  // predictor state
  cfg_t        regs;
  logic [15:0] hold_mv;
  logic        hold_mv_ok;
  stamp_t      t_power, t_det, t_full, det_since, full_since, both_since, t_fault, cv_since;
  logic        cv_latch;
  logic [10:0] last_snap;

  status_t     pending_status[$];
  script_row_t script [19];
  logic [31:0] clock_ms;
  bit          hold_off;
  int          err_cnt, ticks_sent, beats_checked, settings_used, idle_cyc;
  int          state_hits [7];

  function automatic logic [31:0] age(logic [31:0] now, stamp_t s);
    return now - s.t;
  endfunction

  function automatic logic recent(logic [31:0] now, stamp_t s, logic [15:0] lim);
    return s.valid && (age(now, s) <= {16'd0, lim});
  endfunction

  function automatic logic aged(logic [31:0] now, stamp_t s, logic [15:0] lim);
    return s.valid && (age(now, s) >= {16'd0, lim});
  endfunction

  function automatic stamp_t mark(logic [31:0] now);
    stamp_t s;
    s.valid = 1'b1;
    s.t = now;
    return s;
  endfunction

  function automatic status_t decode(charge_state_t st, logic pwr, logic chg);
    status_t r;
    r = '0;
    r.state = st;
    r.ext_power = pwr;
    r.charging = (st == ST_PRE) || (st == ST_CC) || (st == ST_CV);
    r.is_full = (st == ST_FULL);
    r.is_no_battery = (st == ST_NOBAT);
    r.is_precharge = (st == ST_PRE);
    r.is_constant_current = (st == ST_CC);
    r.is_constant_voltage = (st == ST_CV);
    r.is_fault = (st == ST_FAULT);
    r.changed = chg;
    return r;
  endfunction

  task automatic reset_predictor();
    regs.power_hold_ms = 16'd3000;
    regs.stable_high_ms = 16'd2000;
    regs.alternate_window_ms = 16'd3000;
    regs.fault_hold_ms = 16'd5000;
    regs.precharge_below_mv = 16'd3000;
    regs.cv_enter_mv = 16'd4150;
    regs.cv_confirm_ms = 16'd5000;
    regs.detect_active_level = 1'b0;
    hold_mv = '0;
    hold_mv_ok = 1'b0;
    t_power = '0;
    t_det = '0;
    t_full = '0;
    det_since = '0;
    full_since = '0;
    both_since = '0;
    t_fault = '0;
    cv_since = '0;
    cv_latch = 1'b0;
    last_snap = '0;
  endtask

  function automatic status_t classify_tick(logic [31:0] now, logic det_raw, logic full_raw,
                                            logic [15:0] mv, logic mv_ok);
    logic          det, pwr, det_st, full_st, alt, nobat, flt, clr_cv;
    charge_state_t st;
    status_t       res;
    logic [10:0]   snap;
    det = (det_raw == regs.detect_active_level);
    clr_cv = 1'b1;
    if (mv_ok) begin
      hold_mv = mv;
      hold_mv_ok = 1'b1;
    end
    if (det) begin
      t_power = mark(now);
      t_det = mark(now);
      if (!det_since.valid) det_since = mark(now);
    end else begin
      det_since = '0;
    end
    if (full_raw) begin
      t_power = mark(now);
      t_full = mark(now);
      if (!full_since.valid) full_since = mark(now);
    end else begin
      full_since = '0;
    end
    pwr = recent(now, t_power, regs.power_hold_ms);
    det_st = aged(now, det_since, regs.stable_high_ms);
    full_st = aged(now, full_since, regs.stable_high_ms);
    alt = pwr && recent(now, t_det, regs.alternate_window_ms)
              && recent(now, t_full, regs.alternate_window_ms);
    nobat = alt && !det_st && !full_st;
    if (det && full_raw) begin
      if (!both_since.valid) both_since = mark(now);
      if (aged(now, both_since, regs.stable_high_ms)) t_fault = mark(now);
    end else begin
      both_since = '0;
    end
    flt = pwr && recent(now, t_fault, regs.fault_hold_ms);
    if (!pwr) begin
      st = ST_NOPOWER;
      hold_mv_ok = 1'b0;
    end else if (flt) begin
      st = ST_FAULT;
    end else if (nobat) begin
      st = ST_NOBAT;
    end else if (full_st) begin
      st = ST_FULL;
    end else if (hold_mv_ok && hold_mv < regs.precharge_below_mv) begin
      st = ST_PRE;
    end else begin
      clr_cv = 1'b0;
      if (!cv_latch && hold_mv_ok && hold_mv >= regs.cv_enter_mv) begin
        if (!cv_since.valid) cv_since = mark(now);
        else if (age(now, cv_since) >= {16'd0, regs.cv_confirm_ms}) cv_latch = 1'b1;
      end else if (!cv_latch) begin
        cv_since = '0;
      end
      st = cv_latch ? ST_CV : ST_CC;
    end
    if (clr_cv) begin
      cv_since = '0;
      cv_latch = 1'b0;
    end
    res = decode(st, pwr, 1'b0);
    snap = {res.is_fault, res.is_constant_voltage, res.is_constant_current, res.is_precharge,
            res.is_no_battery, res.is_full, res.charging, res.ext_power, res.state};
    res.changed = (snap != last_snap);
    last_snap = snap;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic offer_tick(logic [31:0] now, logic det_raw, logic full_raw, logic [15:0] mv,
                            logic mv_ok, bit tight, logic typed, status_t typed_res);
    int      gap;
    status_t res;
    gap = tight ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'd0, mv_ok, mv, full_raw, det_raw, now};
    do @(posedge clk); while (!in_tready);
    res = classify_tick(now, det_raw, full_raw, mv, mv_ok);
    pending_status.push_back(typed ? typed_res : res);
    ticks_sent++;
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    case (idx)
      CFG_POWER_HOLD:   regs.power_hold_ms = v;
      CFG_STABLE_HIGH:  regs.stable_high_ms = v;
      CFG_ALT_WINDOW:   regs.alternate_window_ms = v;
      CFG_FAULT_HOLD:   regs.fault_hold_ms = v;
      CFG_PRECHARGE_MV: regs.precharge_below_mv = v;
      CFG_CV_ENTER_MV:  regs.cv_enter_mv = v;
      CFG_CV_CONFIRM:   regs.cv_confirm_ms = v;
      CFG_DETECT_LEVEL: regs.detect_active_level = v[0];
      default: ;
    endcase
  endtask

  task automatic load_settings(logic [15:0] ph, logic [15:0] sh, logic [15:0] aw,
                               logic [15:0] fh, logic [15:0] pm, logic [15:0] cm,
                               logic [15:0] cc, logic lvl);
    write_reg(CFG_POWER_HOLD, ph);
    write_reg(CFG_STABLE_HIGH, sh);
    write_reg(CFG_ALT_WINDOW, aw);
    write_reg(CFG_FAULT_HOLD, fh);
    write_reg(CFG_PRECHARGE_MV, pm);
    write_reg(CFG_CV_ENTER_MV, cm);
    write_reg(CFG_CV_CONFIRM, cc);
    write_reg(CFG_DETECT_LEVEL, {15'd0, lvl});
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic drain_status();
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Segments of plausible charger behavior with random timing and voltages,
  // plus some noise. Timestamps only move forward (mod 2^32), with rare jumps.
  task automatic run_random(int n);
    int          left, seg, scen, vmode, pace, r;
    bit          tight;
    logic        det_a, full_a, det_raw, mv_ok;
    logic [15:0] mv;
    status_t     none;
    none = '0;
    left = n;
    clock_ms = $urandom;
    while (left > 0) begin
      scen = $urandom_range(0, 9);
      seg = $urandom_range(4, 40);
      vmode = (scen == 8) ? 2 : $urandom_range(0, 3);
      tight = ($urandom_range(0, 3) == 0);
      pace = (int'(regs.stable_high_ms) + int'(regs.cv_confirm_ms)) / 6 + 1;
      for (int i = 0; i < seg && left > 0; i++) begin
        r = $urandom_range(0, 99);
        if (r < 60) clock_ms += $urandom_range(0, pace);
        else if (r < 90) clock_ms += $urandom_range(0, 3 * pace);
        else if (r < 97) clock_ms += $urandom_range(0, 70000);
        else clock_ms = $urandom;
        case (scen)
          3: begin det_a = 1'b0; full_a = 1'b1; end
          4: begin det_a = i[0]; full_a = !i[0]; end
          5: begin det_a = 1'b1; full_a = 1'b1; end
          6: begin det_a = 1'b0; full_a = 1'b0; end
          7: begin det_a = 1'($urandom); full_a = 1'($urandom); end
          9: begin
            det_a = ($urandom_range(0, 9) > 2);
            full_a = ($urandom_range(0, 9) == 0);
          end
          default: begin det_a = 1'b1; full_a = 1'b0; end
        endcase
        if ($urandom_range(0, 19) == 0) begin
          det_a = 1'($urandom);
          full_a = 1'($urandom);
        end
        case (vmode)
          0: mv = 16'($urandom_range(0, int'(regs.precharge_below_mv)));
          1: mv = 16'($urandom_range(int'(regs.precharge_below_mv), int'(regs.cv_enter_mv)));
          2: mv = 16'($urandom_range(int'(regs.cv_enter_mv), 65535));
          default: mv = 16'($urandom);
        endcase
        mv_ok = ($urandom_range(0, 9) < 7);
        det_raw = det_a ? regs.detect_active_level : !regs.detect_active_level;
        offer_tick(clock_ms, det_raw, full_a, mv, mv_ok, tight, 1'b0, none);
        left--;
      end
    end
    in_tvalid <= 1'b0;
  endtask

  function automatic void cmp(string name, logic [2:0] want, logic [2:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin : status_check
    status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_status.size() == 0) begin
        $error("status beat %h with nothing pending", out_tdata);
        err_cnt++;
      end else begin
        want = pending_status.pop_front();
        cmp("charge_state", want.state, out_tdata[2:0]);
        cmp("ext_power", {2'b0, want.ext_power}, {2'b0, out_tdata[3]});
        cmp("charging", {2'b0, want.charging}, {2'b0, out_tdata[4]});
        cmp("is_full", {2'b0, want.is_full}, {2'b0, out_tdata[5]});
        cmp("is_no_battery", {2'b0, want.is_no_battery}, {2'b0, out_tdata[6]});
        cmp("is_precharge", {2'b0, want.is_precharge}, {2'b0, out_tdata[7]});
        cmp("is_constant_current", {2'b0, want.is_constant_current}, {2'b0, out_tdata[8]});
        cmp("is_constant_voltage", {2'b0, want.is_constant_voltage}, {2'b0, out_tdata[9]});
        cmp("is_fault", {2'b0, want.is_fault}, {2'b0, out_tdata[10]});
        cmp("changed", {2'b0, want.changed}, {2'b0, out_tdata[11]});
        state_hits[want.state]++;
        beats_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= WATCHDOG_LIMIT) begin
      $display("charger_status_classifier test failed");
      $finish;
    end
  end

  // receiver: random ready pattern, one long hold-off on request
  initial begin
    int len;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 5) : $urandom_range(10, 40);
        out_tready <= ($urandom_range(0, 99) < 70);
        repeat (len) @(posedge clk);
      end
    end
  end

  initial begin
    status_t none;
    none = '0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_addr <= CFG_POWER_HOLD;
    cfg_wdata <= '0;
    hold_off = 1'b0;
    reset_predictor();
    // detect pin is active low at reset, so det_raw 0 counts as detect active
    script = '{
      '{32'd1000,       1'b1, 1'b0, 16'd0,     1'b0, 1'b1, ST_NOPOWER, 1'b0, 1'b0},
      '{32'd1010,       1'b0, 1'b0, 16'd3500,  1'b1, 1'b1, ST_CC,      1'b1, 1'b1},
      '{32'd1020,       1'b0, 1'b0, 16'd0,     1'b1, 1'b0, ST_NOPOWER, 1'b0, 1'b0},
      '{32'd1030,       1'b0, 1'b0, 16'hFFFF,  1'b1, 1'b0, ST_NOPOWER, 1'b0, 1'b0},
      '{32'd6030,       1'b0, 1'b0, 16'd0,     1'b0, 1'b0, ST_NOPOWER, 1'b0, 1'b0},
      '{32'd6130,       1'b0, 1'b1, 16'd0,     1'b0, 1'b0, ST_NOPOWER, 1'b0, 1'b0},
      '{32'd8130,       1'b0, 1'b1, 16'd0,     1'b0, 1'b0, ST_NOPOWER, 1'b0, 1'b0},
      '{32'd8140,       1'b1, 1'b0, 16'd0,     1'b0, 1'b0, ST_NOPOWER, 1'b0, 1'b0},
      '{32'd20000,      1'b1, 1'b0, 16'd0,     1'b0, 1'b1, ST_NOPOWER, 1'b0, 1'b1},
      '{32'd20010,      1'b1, 1'b1, 16'd0,     1'b0, 1'b0, ST_NOPOWER, 1'b0, 1'b0},
      '{32'd22010,      1'b1, 1'b1, 16'd0,     1'b0, 1'b0, ST_NOPOWER, 1'b0, 1'b0},
      '{32'd22500,      1'b0, 1'b0, 16'd0,     1'b0, 1'b0, ST_NOPOWER, 1'b0, 1'b0},
      '{32'd23000,      1'b1, 1'b1, 16'd0,     1'b0, 1'b0, ST_NOPOWER, 1'b0, 1'b0},
      '{32'd23500,      1'b0, 1'b0, 16'd0,     1'b0, 1'b0, ST_NOPOWER, 1'b0, 1'b0},
      '{32'hFFFF_FFF0,  1'b0, 1'b0, 16'hFFFF,  1'b1, 1'b0, ST_NOPOWER, 1'b0, 1'b0},
      '{32'h0000_0FF0,  1'b0, 1'b0, 16'd0,     1'b0, 1'b0, ST_NOPOWER, 1'b0, 1'b0},
      '{32'hFFFF_FFFF,  1'b1, 1'b0, 16'h5555,  1'b1, 1'b0, ST_NOPOWER, 1'b0, 1'b0},
      '{32'h0000_0000,  1'b0, 1'b1, 16'hAAAA,  1'b1, 1'b0, ST_NOPOWER, 1'b0, 1'b0},
      '{32'h0000_0000,  1'b0, 1'b1, 16'hAAAA,  1'b0, 1'b0, ST_NOPOWER, 1'b0, 1'b0}
    };
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    settings_used = 1;

    foreach (script[k])
      offer_tick(script[k].now, script[k].det_raw, script[k].full_raw, script[k].mv,
                 script[k].mv_ok, 1'b0, script[k].typed,
                 script[k].typed ? decode(script[k].st, script[k].pwr, script[k].chg) : none);
    run_random(300);
    drain_status();

    load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
    run_random(300);
    drain_status();

    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    hold_off = 1'b1;
    run_random(250);
    drain_status();

    load_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    run_random(300);
    drain_status();

    load_settings(16'd500, 16'd300, 16'd800, 16'd1000, 16'd3300, 16'd4100, 16'd1500, 1'b1);
    run_random(300);
    drain_status();

    load_settings(16'($urandom_range(0, 5000)), 16'($urandom_range(0, 3000)),
                  16'($urandom_range(0, 5000)), 16'($urandom_range(0, 8000)),
                  16'($urandom_range(2500, 3500)), 16'($urandom_range(3800, 4300)),
                  16'($urandom_range(0, 6000)), 1'b0);
    run_random(150);
    drain_status();
    repeat (6) @(posedge clk);

    $display("Sent %0d ticks under %0d register settings, checked %0d status beats.",
             ticks_sent, settings_used, beats_checked);
    $display({"States seen: nopower %0d, precharge %0d, cc %0d, cv %0d, full %0d, ",
              "nobattery %0d, fault %0d"},
             state_hits[0], state_hits[1], state_hits[2], state_hits[3], state_hits[4],
             state_hits[5], state_hits[6]);
    if (err_cnt == 0) begin
      $display("charger_status_classifier test passed");
    end else begin
      $display("charger_status_classifier test failed");
    end
    $finish;
  end

endmodule
